[sv/fetm_pkg.sv]
// Shared constants and types for the force effect table mixer.
`default_nettype none
package fetm_pkg;
    localparam int MAX_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int PWM_MAX   = 2047;
    localparam int DUTY_W    = 11;
    localparam int P_W       = 45;
    localparam int Q_W       = 22;
    localparam int SUM_W     = 26;
    localparam logic [12:0]    SCALE_K  = 13'd8027;
    localparam logic [P_W-1:0] ROUND_K  = P_W'(5000000);
    localparam logic [P_W-1:0] DIVISOR  = P_W'(10000000);

    localparam logic [2:0] MODE_CREATE = 3'd0;
    localparam logic [2:0] MODE_SETEFF = 3'd1;
    localparam logic [2:0] MODE_SETMAG = 3'd2;
    localparam logic [2:0] MODE_OPER   = 3'd3;
    localparam logic [2:0] MODE_FREE   = 3'd4;
    localparam logic [2:0] MODE_DEVICE = 3'd5;
    localparam logic [2:0] MODE_PLAY   = 3'd6;

    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SOLO  = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_EN    = 3'd1;
    localparam logic [2:0] CMD_DIS   = 3'd2;
    localparam logic [2:0] CMD_ALL   = 3'd3;

    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_CONST = 4'd1;
    localparam logic [3:0] KIND_LAST  = 4'd11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_TYPE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic vld;
        logic en;
        logic neg;
        logic last;
    } t_tag;

    typedef struct packed {
        logic [P_W-1:0] rem;
        logic [Q_W-1:0] q;
        t_tag           tag;
    } t_cell;
endpackage
`default_nettype wire

[sv/fetm_div_cell.sv]
// One quotient bit of the divide-by-ten-million chain.
`default_nettype none
module fetm_div_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [4:0]     i_shift,
    input  wire fetm_pkg::t_cell i_d,
    output fetm_pkg::t_cell     o_d
);
    import fetm_pkg::*;
    logic [P_W-1:0] w_div;
    logic           w_ge;
    t_cell          r_d;

    assign w_div = DIVISOR << i_shift;
    assign w_ge  = i_d.rem >= w_div;

    always_ff @(posedge i_clk) begin
        r_d.rem <= w_ge ? i_d.rem - w_div : i_d.rem;
        r_d.q   <= {i_d.q[Q_W-2:0], w_ge};
        r_d.tag <= i_d.tag;
        if (!i_rst_n) begin
            r_d.tag.vld <= 1'b0;
        end
    end
    assign o_d = r_d;
endmodule
`default_nettype wire

[sv/fetm_term_pipe.sv]
// Pipelined term of one slot: products, rounding and the divider cell chain.
`default_nettype none
module fetm_term_pipe (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fetm_pkg::t_tag i_tag,
    input  wire logic [15:0]   i_mag,
    input  wire logic [7:0]    i_gain,
    input  wire logic [6:0]    i_pct,
    output fetm_pkg::t_tag     o_tag,
    output logic [fetm_pkg::Q_W-1:0] o_q
);
    import fetm_pkg::*;
    logic [15:0] w_abs;
    logic [23:0] r1;
    logic [6:0]  r1_pct;
    logic [30:0] r2;
    logic [P_W-2:0] w_scl;
    logic [P_W-1:0] r3;
    t_tag        r1_tag, r2_tag, r3_tag;
    t_cell       w_chain [Q_W+1];

    assign w_abs = i_mag[15] ? 16'(-i_mag) : i_mag;
    // full-width product of the 31-bit partial and the 13-bit scale
    assign w_scl = r2 * SCALE_K;

    always_ff @(posedge i_clk) begin
        r1     <= w_abs * i_gain;
        r1_pct <= i_pct;
        r1_tag <= i_tag;
        r2     <= r1 * r1_pct;
        r2_tag <= r1_tag;
        r3     <= {1'b0, w_scl} + ROUND_K;
        r3_tag <= r2_tag;
        if (!i_rst_n) begin
            r1_tag.vld <= 1'b0;
            r2_tag.vld <= 1'b0;
            r3_tag.vld <= 1'b0;
        end
    end

    assign w_chain[0] = '{rem: r3, q: '0, tag: r3_tag};

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        fetm_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(5'(Q_W - 1 - g)),
            .i_d    (w_chain[g]),
            .o_d    (w_chain[g+1])
        );
    end

    assign o_tag = w_chain[Q_W].tag;
    assign o_q   = w_chain[Q_W].q;
endmodule
`default_nettype wire

[sv/force_effect_table_mixer.sv]
// Top level: slot table, request sequencer, term accumulation and result register.
// Table writes and device commands go straight to the result state; create first walks
// the table, and a play tick issues one slot a cycle into the term pipe, then drains it.
// Throughput: one item at a time; the next is taken once the result is registered.
// The result register holds while o_m_tvalid waits; one more request is taken and waits in S_WR.
// Synchronous active-low reset clears the table, flags, duties and held status.
`default_nettype none
module force_effect_table_mixer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // slot[5:0], effect_type[9:6], effect_gain[16:10], magnitude[32:17], command[35:33]
    input  wire logic [39:0] i_s_tdata,
    // mode[2:0]
    input  wire logic [2:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // new_slot[5:0], load_status[7:6], left_drive[18:8], right_drive[29:19], actuator_on[30]
    output logic [31:0]      o_m_tdata
);
    import fetm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;

    logic [3:0]  r_kind [MAX_SLOTS];
    logic [6:0]  r_pct  [MAX_SLOTS];
    logic [15:0] r_frc  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_run;
    logic [7:0]  r_gain;
    logic        r_en;
    logic [DUTY_W-1:0] r_left, r_right;
    logic [5:0]  r_found;
    logic [1:0]  r_status;
    logic [2:0]  r_state;
    logic [SLOT_W-1:0] r_idx;
    logic signed [SUM_W-1:0] r_sum;
    logic        r_ovalid;
    logic [31:0] r_odata;

    logic        w_acc;
    logic [2:0]  w_mode;
    logic [5:0]  w_slot;
    logic [3:0]  w_type;
    logic [6:0]  w_pg;
    logic [15:0] w_mag;
    logic [2:0]  w_cmd;
    logic        w_valid;
    logic [SLOT_W-1:0] w_sidx;
    t_tag        w_itag, w_otag;
    logic [Q_W-1:0] w_q;
    logic signed [SUM_W-1:0] w_term, w_fsum;
    logic        w_free;

    assign w_mode  = i_s_tuser;
    assign w_slot  = i_s_tdata[5:0];
    assign w_type  = i_s_tdata[9:6];
    assign w_pg    = i_s_tdata[16:10];
    assign w_mag   = i_s_tdata[32:17];
    assign w_cmd   = i_s_tdata[35:33];
    assign w_valid = (w_slot >= 6'd1) && (w_slot <= 6'(MAX_SLOTS));
    assign w_sidx  = SLOT_W'(w_slot - 6'd1);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_free     = !r_ovalid || i_m_tready;

    assign w_itag = '{vld:  r_state == S_ISSUE,
                      en:   r_kind[r_idx] == KIND_CONST && r_run[r_idx],
                      neg:  r_frc[r_idx][15],
                      last: r_idx == SLOT_W'(MAX_SLOTS - 1)};

    fetm_term_pipe u_pipe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tag  (w_itag),
        .i_mag  (r_frc[r_idx]),
        .i_gain (r_gain),
        .i_pct  (r_pct[r_idx]),
        .o_tag  (w_otag),
        .o_q    (w_q)
    );

    assign w_term = !w_otag.en ? '0 :
                    w_otag.neg ? -SUM_W'(w_q) : SUM_W'(w_q);
    assign w_fsum = r_sum + w_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_kind[k] <= KIND_NONE;
                r_pct[k]  <= '0;
                r_frc[k]  <= '0;
            end
            r_run    <= '0;
            r_gain   <= '0;
            r_en     <= 1'b0;
            r_left   <= '0;
            r_right  <= '0;
            r_found  <= '0;
            r_status <= ST_OK;
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (r_state == S_WR && w_free) begin
                r_ovalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_idx <= '0;
                        if (w_mode == MODE_CREATE && w_type >= KIND_CONST &&
                            w_type <= KIND_LAST) begin
                            r_state <= S_FIND;
                        end else if (w_mode == MODE_PLAY && r_en) begin
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_WR;
                        end
                        case (w_mode)
                            MODE_CREATE: begin
                                if (!(w_type >= KIND_CONST && w_type <= KIND_LAST)) begin
                                    r_found  <= '0;
                                    r_status <= ST_TYPE;
                                end
                            end
                            MODE_SETEFF: begin
                                if (w_valid) begin
                                    r_kind[w_sidx] <= w_type;
                                    r_pct[w_sidx]  <= w_pg;
                                end
                            end
                            MODE_SETMAG: begin
                                if (w_valid) begin
                                    r_frc[w_sidx] <= w_mag;
                                end
                            end
                            MODE_OPER: begin
                                if (w_valid) begin
                                    if (w_cmd == CMD_START) begin
                                        r_run[w_sidx] <= 1'b1;
                                    end else if (w_cmd == CMD_SOLO) begin
                                        r_run <= MAX_SLOTS'(1) << w_sidx;
                                    end else if (w_cmd == CMD_STOP) begin
                                        r_run[w_sidx] <= 1'b0;
                                    end
                                end
                            end
                            MODE_FREE: begin
                                if (w_valid) begin
                                    r_run[w_sidx]  <= 1'b0;
                                    r_kind[w_sidx] <= KIND_NONE;
                                    r_pct[w_sidx]  <= '0;
                                    r_frc[w_sidx]  <= '0;
                                end
                            end
                            MODE_DEVICE: begin
                                if (w_cmd == CMD_EN) begin
                                    r_en <= 1'b1;
                                end else if (w_cmd == CMD_DIS) begin
                                    r_run   <= '0;
                                    r_en    <= 1'b0;
                                    r_left  <= '0;
                                    r_right <= '0;
                                end else if (w_cmd == CMD_ALL) begin
                                    r_run <= '0;
                                end
                            end
                            MODE_PLAY: begin
                                r_left  <= '0;
                                r_right <= '0;
                                r_sum   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    // walk the table for the first free slot
                    if (r_kind[r_idx] == KIND_NONE) begin
                        r_found  <= 6'(r_idx) + 6'd1;
                        r_status <= ST_OK;
                        r_state  <= S_WR;
                    end else if (r_idx == SLOT_W'(MAX_SLOTS - 1)) begin
                        r_found  <= '0;
                        r_status <= ST_FULL;
                        r_state  <= S_WR;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_ISSUE, S_DRAIN: begin
                    if (r_state == S_ISSUE) begin
                        r_idx <= r_idx + 1'b1;
                        if (w_itag.last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                    if (w_otag.vld) begin
                        r_sum <= w_fsum;
                        if (w_otag.last) begin
                            if (w_fsum > 0) begin
                                r_left <= (w_fsum > SUM_W'(PWM_MAX)) ?
                                          DUTY_W'(PWM_MAX) : w_fsum[DUTY_W-1:0];
                            end else if (w_fsum < 0) begin
                                r_right <= (-w_fsum > SUM_W'(PWM_MAX)) ?
                                           DUTY_W'(PWM_MAX) : DUTY_W'(-w_fsum);
                            end
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    // hold until the result register is free
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && w_free) begin
            r_odata <= {1'b0, r_en, r_right, r_left, r_status, r_found};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left == '0) || (r_right == '0))
        else $error("both bridge sides driven");
    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |-> (r_left == '0 && r_right == '0))
        else $error("drive while actuators disabled");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found != '0) |-> (r_status == ST_OK && r_found <= 6'(MAX_SLOTS)))
        else $error("found slot inconsistent with status");
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_otag.vld && w_otag.last) |=> (r_state == S_WR))
        else $error("play tick did not close");
endmodule
`default_nettype wire

[verif/force_effect_table_mixer_check.sv]
// Checker for the force effect table mixer: predicts each result beat and compares it.
`timescale 1ns / 1ps
module force_effect_table_mixer_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,
    input  wire logic [2:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    output int               o_errors,
    output int               o_pending
);
    import fetm_pkg::*;

    logic [7:0]  dev_gain;
    logic [3:0]  kind_tab [MAX_SLOTS];
    logic [6:0]  pct_tab [MAX_SLOTS];
    logic [15:0] force_tab [MAX_SLOTS];
    logic        run_tab [MAX_SLOTS];
    logic        enabled;
    logic [10:0] left_duty, right_duty;
    logic [5:0]  held_slot;
    logic [1:0]  held_status;
    logic [31:0] expected_beats [$];

    assign o_pending = expected_beats.size();

    task automatic report_mismatch(input string what, input logic [31:0] got, exp);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
        o_errors++;
    endtask

    function automatic longint slot_force_term(input int i);
        logic        neg;
        longint      mag, prod, t;
        neg  = force_tab[i][15];
        mag  = neg ? (65536 - force_tab[i]) : force_tab[i];
        prod = mag * dev_gain * pct_tab[i] * 8027;
        t    = (prod + 5000000) / 10000000;
        return neg ? -t : t;
    endfunction

    task automatic predict_mixer(input logic [2:0] mode, input logic [39:0] d);
        logic [5:0]  slot;
        logic [3:0]  kind;
        logic [2:0]  cmd;
        logic        ok;
        int          idx;
        longint      sum;
        slot = d[5:0];
        kind = d[9:6];
        cmd  = d[35:33];
        ok   = slot >= 1 && slot <= MAX_SLOTS;
        idx  = ok ? slot - 1 : 0;
        case (mode)
            MODE_CREATE: begin
                if (kind >= KIND_CONST && kind <= KIND_LAST) begin
                    held_slot = 0;
                    held_status = ST_FULL;
                    for (int i = MAX_SLOTS - 1; i >= 0; i--)
                        if (kind_tab[i] == KIND_NONE) begin
                            held_slot = 6'(i + 1);
                            held_status = ST_OK;
                        end
                end else begin
                    held_slot = 0;
                    held_status = ST_TYPE;
                end
            end
            MODE_SETEFF: if (ok) begin
                kind_tab[idx] = kind;
                pct_tab[idx] = d[16:10];
            end
            MODE_SETMAG: if (ok) force_tab[idx] = d[32:17];
            MODE_OPER: if (ok) begin
                if (cmd == CMD_START) run_tab[idx] = 1;
                else if (cmd == CMD_SOLO) begin
                    foreach (run_tab[i]) run_tab[i] = 0;
                    run_tab[idx] = 1;
                end else if (cmd == CMD_STOP) run_tab[idx] = 0;
            end
            MODE_FREE: if (ok) begin
                run_tab[idx] = 0;
                kind_tab[idx] = KIND_NONE;
                pct_tab[idx] = 0;
                force_tab[idx] = 0;
            end
            MODE_DEVICE: begin
                if (cmd == CMD_EN) enabled = 1;
                else if (cmd == CMD_DIS) begin
                    foreach (run_tab[i]) run_tab[i] = 0;
                    enabled = 0;
                    left_duty = 0;
                    right_duty = 0;
                end else if (cmd == CMD_ALL) foreach (run_tab[i]) run_tab[i] = 0;
            end
            MODE_PLAY: begin
                left_duty = 0;
                right_duty = 0;
                if (enabled) begin
                    sum = 0;
                    for (int i = 0; i < MAX_SLOTS; i++)
                        if (kind_tab[i] == KIND_CONST && run_tab[i])
                            sum += slot_force_term(i);
                    if (sum > 0) left_duty = 11'(sum > PWM_MAX ? PWM_MAX : sum);
                    else if (sum < 0) right_duty = 11'(-sum > PWM_MAX ? PWM_MAX : -sum);
                end
            end
            default: ;
        endcase
        expected_beats.push_back({1'b0, enabled, right_duty, left_duty, held_status,
                                  held_slot});
    endtask

    always @(posedge i_clk) begin
        logic [31:0] exp;
        if (!i_rst_n) begin
            dev_gain = 0;
            foreach (kind_tab[i]) begin
                kind_tab[i] = 0;
                pct_tab[i] = 0;
                force_tab[i] = 0;
                run_tab[i] = 0;
            end
            enabled = 0;
            left_duty = 0;
            right_duty = 0;
            held_slot = 0;
            held_status = 0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) dev_gain = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) predict_mixer(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata, 0);
                end else begin
                    exp = expected_beats.pop_front();
                    if (i_m_tdata[5:0] != exp[5:0])
                        report_mismatch("new_slot", i_m_tdata[5:0], exp[5:0]);
                    if (i_m_tdata[7:6] != exp[7:6])
                        report_mismatch("load_status", i_m_tdata[7:6], exp[7:6]);
                    if (i_m_tdata[18:8] != exp[18:8])
                        report_mismatch("left_drive", i_m_tdata[18:8], exp[18:8]);
                    if (i_m_tdata[29:19] != exp[29:19])
                        report_mismatch("right_drive", i_m_tdata[29:19], exp[29:19]);
                    if (i_m_tdata[30] != exp[30])
                        report_mismatch("actuator_on", i_m_tdata[30], exp[30]);
                end
            end
        end
    end
endmodule

[verif/force_effect_table_mixer_test.sv]
// Stimulus and verdict for the force effect table mixer test.
`timescale 1ns / 1ps
module force_effect_table_mixer_test;
    import fetm_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [7:0]  i_cfg_wdata = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = 0;
    logic [2:0]  i_s_tuser = 0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [31:0] o_m_tdata;
    int          errors, pending, idle_cycles;
    bit          hold_off = 0, sink_on = 0;

    always #6 i_clk = ~i_clk;

    force_effect_table_mixer dut (.*);

    force_effect_table_mixer_check checker_inst (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata, .i_s_tvalid,
        .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser, .i_m_tvalid(o_m_tvalid),
        .i_m_tready, .i_m_tdata(o_m_tdata), .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Receiver: random stalls, with one long hold-off requested by the sender.
    always @(posedge i_clk) begin
        if (!sink_on) i_m_tready <= 0;
        else if (hold_off) i_m_tready <= 0;
        else i_m_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0] mode, input logic [5:0] slot,
                                input logic [3:0] kind, input logic [6:0] gain,
                                input logic [15:0] mag, input logic [2:0] cmd,
                                input bit gaps);
        int g;
        g = gaps ? gap_length() : 0;
        if (g > 0) begin
            i_s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {4'b0, cmd, mag, gain, kind, slot};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain_and_set_gain(input logic [7:0] g);
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_request(input bit gaps);
        logic [2:0]  mode;
        logic [5:0]  slot;
        int r;
        r = $urandom_range(0, 99);
        // Mostly valid, low-numbered slots so the table fills and plays carry weight.
        slot = (r < 85) ? $urandom_range(1, 8) : $urandom_range(0, 63);
        if (r < 10) mode = MODE_CREATE;
        else if (r < 28) mode = MODE_SETEFF;
        else if (r < 45) mode = MODE_SETMAG;
        else if (r < 62) mode = MODE_OPER;
        else if (r < 68) mode = MODE_FREE;
        else if (r < 76) mode = MODE_DEVICE;
        else if (r < 98) mode = MODE_PLAY;
        else mode = 3'd7;
        send_request(mode, slot,
                     ($urandom_range(0, 2) == 0) ? 4'($urandom) : KIND_CONST,
                     ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100)),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($signed($urandom_range(0, 200)) - 100),
                     ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 3)),
                     gaps);
    endtask

    initial begin
        logic [7:0] gains [5] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd200};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        sink_on <= 1;
        drain_and_set_gain(8'd255);
        // Directed: create, fill, extremes, solo, stop all, disable, bad slots.
        send_request(MODE_CREATE, 0, 4'd12, 0, 0, 0, 0);
        send_request(MODE_CREATE, 0, 4'd0, 0, 0, 0, 0);
        send_request(MODE_CREATE, 0, 4'd15, 0, 0, 0, 0);
        send_request(MODE_CREATE, 0, KIND_CONST, 0, 0, 0, 0);
        send_request(MODE_PLAY, 0, 0, 0, 0, 0, 0);
        send_request(MODE_DEVICE, 0, 0, 0, 0, CMD_EN, 0);
        send_request(MODE_SETEFF, 1, KIND_CONST, 7'd127, 0, 0, 0);
        send_request(MODE_SETMAG, 1, 0, 0, 16'h7FFF, 0, 0);
        send_request(MODE_SETEFF, 32, KIND_CONST, 7'd100, 0, 0, 0);
        send_request(MODE_SETMAG, 32, 0, 0, 16'h8000, 0, 0);
        send_request(MODE_OPER, 1, 0, 0, 0, CMD_START, 0);
        send_request(MODE_PLAY, 0, 0, 0, 0, 0, 0);
        send_request(MODE_OPER, 32, 0, 0, 0, CMD_SOLO, 0);
        send_request(MODE_PLAY, 0, 0, 0, 0, 0, 0);
        send_request(MODE_SETEFF, 0, KIND_CONST, 7'd50, 0, 0, 0);
        send_request(MODE_SETMAG, 6'd63, 0, 0, 16'hFFFF, 0, 0);
        send_request(MODE_OPER, 1, 0, 0, 0, 3'd7, 0);
        send_request(MODE_DEVICE, 0, 0, 0, 0, CMD_ALL, 0);
        send_request(MODE_PLAY, 0, 0, 0, 0, 0, 0);
        send_request(MODE_FREE, 32, 0, 0, 0, 0, 0);
        send_request(MODE_DEVICE, 0, 0, 0, 0, CMD_DIS, 0);
        send_request(MODE_DEVICE, 0, 0, 0, 0, 3'd6, 0);
        send_request(3'd7, 0, 0, 0, 0, 0, 0);
        send_request(MODE_PLAY, 0, 0, 0, 0, 0, 0);
        // Fill the table to reach the full status.
        for (int s = 1; s <= MAX_SLOTS; s++)
            send_request(MODE_SETEFF, s, 4'($urandom_range(1, 11)), 7'd10, 0, 0, 0);
        send_request(MODE_CREATE, 0, KIND_LAST, 0, 0, 0, 0);
        send_request(MODE_FREE, 17, 0, 0, 0, 0, 0);
        send_request(MODE_CREATE, 0, 4'd5, 0, 0, 0, 0);
        // Back-pressure: stall the receiver while requests keep coming.
        hold_off <= 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off <= 0;
            end
            repeat (6) send_request(MODE_DEVICE, 0, 0, 0, 0, CMD_EN, 0);
        join
        for (int ph = 0; ph < 5; ph++) begin
            drain_and_set_gain(gains[ph]);
            send_request(MODE_DEVICE, 0, 0, 0, 0, CMD_EN, 0);
            for (int n = 0; n < 350; n++) random_request(ph != 2);
        end
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
